@@ src/smpq_pkg.sv @@
// Shared types and codes for the sorted max-priority queue.
`timescale 1ns / 1ps

package smpq_pkg;

    localparam int HANDLE_W = 16;
    localparam int RANK_W   = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Command codes; the unused code behaves as peek
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL_DROP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_DEL = 2'd2;

    // One stored entry
    typedef struct packed {
        logic                occ;
        logic [HANDLE_W-1:0] handle;
        logic [RANK_W-1:0]   rank;
    } t_entry;

    // Operation broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_op;

endpackage

@@ src/smpq_cell.sv @@
// One slot of the sorted chain: holds an entry, compares, shifts to/from neighbors.
`timescale 1ns / 1ps

module smpq_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  smpq_pkg::t_op                 i_op,
    input  logic [smpq_pkg::HANDLE_W-1:0] i_new_handle,
    input  logic [smpq_pkg::RANK_W-1:0]   i_new_rank,
    input  smpq_pkg::t_entry              i_prev,       // neighbor toward the head
    input  logic                          i_prev_keep,  // neighbor toward the head holds
    input  smpq_pkg::t_entry              i_next,       // neighbor toward the tail
    output smpq_pkg::t_entry              o_entry,
    output smpq_pkg::t_entry              o_next_entry,
    output logic                          o_keep
);
    import smpq_pkg::*;

    logic                r_occ;
    logic [HANDLE_W-1:0] r_handle;
    logic [RANK_W-1:0]   r_rank;
    t_entry              n_entry;

    // Entry stays put on insert if it ranks equal or above the new one
    assign o_keep = r_occ && (r_rank >= i_new_rank);

    // Next entry selection
    always_comb begin
        n_entry = '{occ: r_occ, handle: r_handle, rank: r_rank};
        if (i_op.ins) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_entry = '{occ: 1'b1, handle: i_new_handle, rank: i_new_rank};
                end else begin
                    n_entry = i_prev;
                end
            end
        end else if (i_op.del) begin
            n_entry = i_next;
        end
    end

    // Occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_entry.occ;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_handle <= n_entry.handle;
        r_rank   <= n_entry.rank;
    end

    assign o_entry      = '{occ: r_occ, handle: r_handle, rank: r_rank};
    assign o_next_entry = n_entry;

endmodule

@@ src/sorted_max_priority_queue.sv @@
// Top level: sorted max-priority queue built as a chain of compare-and-shift cells.
//
//  Channel  | Dir | tdata (low bit up)                           | tuser
//  s_axis   | in  | item_handle[15:0], item_rank[31:16]          | command[1:0]
//  m_axis   | out | head_handle[15:0], head_rank[31:16],         | status[1:0]
//           |     | head_present[32], entry_count[37:33], pad    |
//
// One transaction per cycle while s_axis_tready is high: every cell compares and
// shifts in the accept cycle, and the result is registered from cell 0's next value
// in that same edge. m_axis_tvalid rises in the cycle after accept.
// s_axis_tready is high whenever the output register is empty or being drained.
// Reset is synchronous, active low, and empties the queue; no clearing pass.
`timescale 1ns / 1ps

module sorted_max_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // item_handle, item_rank
    input  logic [1:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // head_handle, head_rank, head_present, entry_count
    output logic [1:0]  m_axis_tuser    // status
);
    import smpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CMD_W-1:0]    in_cmd;
    logic [HANDLE_W-1:0] in_handle;
    logic [RANK_W-1:0]   in_rank;
    logic                accept;
    logic                full;
    logic                empty;
    t_op                 op;
    logic [STATUS_W-1:0] status;

    t_entry              ent      [CAPACITY];
    t_entry              ent_next [CAPACITY];
    logic                keep     [CAPACITY];

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW+COUNT_W-1:0] count_ext;

    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_head_handle;
    logic [RANK_W-1:0]   r_head_rank;
    logic                r_head_present;
    logic [COUNT_W-1:0]  r_entry_count;
    logic [STATUS_W-1:0] r_status;

    // Input unpacking
    assign in_cmd    = s_axis_tuser;
    assign in_handle = s_axis_tdata[15:0];
    assign in_rank   = s_axis_tdata[31:16];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Command decode
    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);
    assign op    = '{ins: accept && (in_cmd == CMD_INSERT) && !full,
                     del: accept && (in_cmd == CMD_DELETE) && !empty};

    always_comb begin
        status = ST_DONE;
        case (in_cmd)
            CMD_INSERT: status = full  ? ST_FULL_DROP : ST_DONE;
            CMD_DELETE: status = empty ? ST_EMPTY_DEL : ST_DONE;
            CMD_PEEK:   status = ST_DONE;
            default:    status = ST_DONE;
        endcase
    end

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_entry prev_ent;
        t_entry next_ent;
        logic   prev_keep;

        if (i == 0) begin : g_head
            assign prev_ent  = '0;
            assign prev_keep = 1'b1;
        end else begin : g_mid
            assign prev_ent  = ent[i-1];
            assign prev_keep = keep[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign next_ent = '0;
        end else begin : g_body
            assign next_ent = ent[i+1];
        end

        smpq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (op),
            .i_new_handle (in_handle),
            .i_new_rank   (in_rank),
            .i_prev       (prev_ent),
            .i_prev_keep  (prev_keep),
            .i_next       (next_ent),
            .o_entry      (ent[i]),
            .o_next_entry (ent_next[i]),
            .o_keep       (keep[i])
        );
    end

    // Entry count
    always_comb begin
        n_count = r_count;
        if (op.ins) begin
            n_count = r_count + CW'(1);
        end else if (op.del) begin
            n_count = r_count - CW'(1);
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head_handle  <= ent_next[0].occ ? ent_next[0].handle : '0;
            r_head_rank    <= ent_next[0].occ ? ent_next[0].rank : '0;
            r_head_present <= ent_next[0].occ;
            r_entry_count  <= count_ext[COUNT_W-1:0];
            r_status       <= status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_entry_count, r_head_present, r_head_rank, r_head_handle};
    assign m_axis_tuser  = r_status;

endmodule

@@ src/smpq_checker.sv @@
// Port-level checks for the sorted max-priority queue, bound to the top level.
`timescale 1ns / 1ps

module smpq_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import smpq_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Empty queue reports zero head and zero count
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0
            && m_axis_tdata[37:33] == 5'd0)
        else $error("empty queue reports a head or count");

    // Dropped insert means the queue holds entries
    a_full_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_FULL_DROP |-> m_axis_tdata[32])
        else $error("full status on an empty queue");

    // Ignored delete means the queue is empty
    a_empty_del: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY_DEL |-> !m_axis_tdata[32]
            && m_axis_tdata[37:33] == 5'd0)
        else $error("empty-delete status on a non-empty queue");

    // A result always follows an accepted transaction
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after accepted transaction");

endmodule

bind sorted_max_priority_queue smpq_port_checker u_smpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
